@@ rtl/cmf_pkg.sv @@
package cmf_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;
	localparam int PIX_W      = 32;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic                    operation;
		logic signed [PIX_W-1:0] pixel_value;
	} item_t;

	typedef struct packed {
		logic signed [PIX_W-1:0] median_value;
		logic                    end_of_row;
		logic                    end_of_frame;
	} result_t;

	typedef struct packed {
		logic             live;
		logic             emit;
		logic             wr_en;
		logic [COL_W-1:0] col;
		logic             has_up;
		logic             has_down;
		logic             has_left;
		logic             has_right;
		logic             eor;
		logic             eof;
	} ctrl_t;

	// Median of five signed words: the smaller of the two pair minimums can never be the
	// median, so the answer is the second smallest of the four that remain.
	function automatic logic signed [PIX_W-1:0] median5(
		input logic signed [PIX_W-1:0] a,
		input logic signed [PIX_W-1:0] b,
		input logic signed [PIX_W-1:0] c,
		input logic signed [PIX_W-1:0] d,
		input logic signed [PIX_W-1:0] e
	);
		logic signed [PIX_W-1:0] p0, p1, q0, q1, x, lo, hi, e0, e1, med;
		p0 = (b < a) ? b : a;
		p1 = (b < a) ? a : b;
		q0 = (d < c) ? d : c;
		q1 = (d < c) ? c : d;
		if (q0 < p0) begin
			x  = q1;
			lo = p0;
			hi = p1;
		end else begin
			x  = p1;
			lo = q0;
			hi = q1;
		end
		e0 = (x < e) ? x : e;
		e1 = (x < e) ? e : x;
		if (e0 < lo) begin
			med = (e1 < lo) ? e1 : lo;
		end else begin
			med = (hi < e0) ? hi : e0;
		end
		return med;
	endfunction

endpackage

@@ rtl/cross_median_filter_core.sv @@
// Five-point cross median filter over a pixel stream in row-major order. One item (pixel or flush)
// is taken per clock unless the output stalls. The result for a pixel comes out when the pixel
// below it arrives; after the last row of a frame one flush per pixel drains it, and end_of_frame
// marks the last result. The rate is set by a single 1024 x 64 row buffer, written at most once
// and read at two addresses per item; it needs no clearing after reset. Writing frame_width or
// frame_height restarts the frame; the user must do so only while idle; the block does not check.
module cross_median_filter_core import cmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [WIDTH_W-1:0]  frame_width_q;
	logic [HEIGHT_W-1:0] frame_height_q;
	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic                cfg_wr;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             draining_q;
	logic signed [PIX_W-1:0] left_q;

	logic                    valid_s1;
	ctrl_t                   ctrl_s1;
	logic signed [PIX_W-1:0] pix_s1;
	logic [2*PIX_W-1:0]      rd_a_s1;
	logic [PIX_W-1:0]        rd_b_s1;
	logic                    byp_a_s1;
	logic                    byp_b_s1;
	logic [2*PIX_W-1:0]      byp_data_s1;

	logic [2*PIX_W-1:0] row_mem [MAX_WIDTH];

	logic               result_valid_q;
	result_t            result_q;

	logic  accept, s1_go, wr_now, row_end, pix_take, flush_take;
	ctrl_t ctrl_d;
	logic [COL_W-1:0]   col_right;
	logic [2*PIX_W-1:0] wdata;
	logic signed [PIX_W-1:0] centre, up_v, down_v, left_v, right_v, up_raw, right_raw, med;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? 32'(frame_height_q) : 32'(frame_width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_W'(1024);
			frame_height_q <= HEIGHT_W'(1024);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_FRAME_WIDTH) begin
				frame_width_q <= pwdata[WIDTH_W-1:0];
			end else begin
				frame_height_q <= pwdata[HEIGHT_W-1:0];
			end
		end
	end

	// Zero sizes behave as one; width clamps to the buffer depth, height to MAX_HEIGHT.
	assign w_eff = (frame_width_q == '0) ? WIDTH_W'(1) :
		(frame_width_q > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : frame_width_q;
	assign h_eff = (frame_height_q == '0) ? HEIGHT_W'(1) :
		(frame_height_q > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT) : frame_height_q;

	// Handshake
	assign s1_go      = valid_s1 && (!ctrl_s1.emit || !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || s1_go;
	assign accept     = item_valid && item_ready;
	assign wr_now     = s1_go && ctrl_s1.wr_en;

	// Position decode for the incoming item
	assign row_end    = (WIDTH_W'(col_q) + WIDTH_W'(1)) >= w_eff;
	assign pix_take   = (item.operation == OP_PIXEL) && !draining_q;
	assign flush_take = (item.operation == OP_FLUSH) && draining_q;
	assign col_right  = col_q + COL_W'(1);

	always_comb begin
		ctrl_d           = '0;
		ctrl_d.live      = pix_take || flush_take;
		ctrl_d.emit      = (pix_take && (row_q != '0)) || flush_take;
		ctrl_d.wr_en     = pix_take;
		ctrl_d.col       = col_q;
		ctrl_d.has_up    = pix_take ? (row_q >= ROW_W'(2)) : (row_q != '0);
		ctrl_d.has_down  = pix_take;
		ctrl_d.has_left  = (col_q != '0);
		ctrl_d.has_right = !row_end;
		ctrl_d.eor       = row_end;
		ctrl_d.eof       = flush_take && row_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			draining_q <= 1'b0;
		end else if (cfg_wr) begin
			col_q      <= '0;
			row_q      <= '0;
			draining_q <= 1'b0;
		end else if (accept && pix_take) begin
			if (row_end) begin
				col_q <= '0;
				if ((HEIGHT_W'(row_q) + HEIGHT_W'(1)) >= h_eff) begin
					draining_q <= 1'b1;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end else if (accept && flush_take) begin
			if (row_end) begin
				col_q      <= '0;
				row_q      <= '0;
				draining_q <= 1'b0;
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Row buffer: each entry holds {pixel two rows up, pixel one row up} for its column.
	// A write in the same cycle as a read of that entry is forwarded from byp_data_s1.
	always_ff @(posedge clk) begin
		if (wr_now) begin
			row_mem[ctrl_s1.col] <= wdata;
		end
		if (accept) begin
			rd_a_s1     <= row_mem[col_q];
			rd_b_s1     <= row_mem[col_right][PIX_W-1:0];
			byp_a_s1    <= wr_now && (ctrl_s1.col == col_q);
			byp_b_s1    <= wr_now && (ctrl_s1.col == col_right);
			byp_data_s1 <= wdata;
			pix_s1      <= item.pixel_value;
			ctrl_s1     <= ctrl_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1: cross gather and median
	assign centre    = byp_a_s1 ? byp_data_s1[PIX_W-1:0] : rd_a_s1[PIX_W-1:0];
	assign up_raw    = byp_a_s1 ? byp_data_s1[2*PIX_W-1:PIX_W] : rd_a_s1[2*PIX_W-1:PIX_W];
	assign right_raw = byp_b_s1 ? byp_data_s1[PIX_W-1:0] : rd_b_s1;
	assign wdata     = {centre, pix_s1};

	assign up_v    = ctrl_s1.has_up    ? up_raw    : centre;
	assign down_v  = ctrl_s1.has_down  ? pix_s1    : centre;
	assign left_v  = ctrl_s1.has_left  ? left_q    : centre;
	assign right_v = ctrl_s1.has_right ? right_raw : centre;
	assign med     = median5(centre, up_v, down_v, left_v, right_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (s1_go && ctrl_s1.live) begin
			left_q <= centre;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_go && ctrl_s1.emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && ctrl_s1.emit) begin
			result_q.median_value <= med;
			result_q.end_of_row   <= ctrl_s1.eor;
			result_q.end_of_frame <= ctrl_s1.eof;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		WIDTH_W'(col_q) < w_eff)
		else $error("column position is past the end of the row");

	a_drain_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> ((HEIGHT_W'(row_q) + HEIGHT_W'(1)) >= h_eff))
		else $error("draining while not on the last row");

	a_eof_is_eor: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.end_of_frame) |-> result_q.end_of_row)
		else $error("end of frame without end of row");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_go) |=> (valid_s1 && $stable(ctrl_s1) && $stable(pix_s1)))
		else $error("stalled stage 1 transaction changed");

endmodule

@@ tb/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cmf_pkg::*;

	localparam int CROSS_SIZE   = 5;
	localparam int RANDOM_ITEMS = 950;
	localparam int BIG_ITEMS    = 64;
	localparam int IDLE_PAUSE   = 8;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int REPORT_CAP   = 100;

	typedef enum int {
		SINK_READY,
		SINK_COIN,
		SINK_RARE_STALL,
		SINK_RUNS
	} sink_mode_e;

	// Tracks the frame position and both stored rows, and queues the median that each
	// accepted transaction that emits a result should produce.
	class cross_median_tracker;
		logic [PIX_W-1:0]    older_row [MAX_WIDTH];
		logic [PIX_W-1:0]    newer_row [MAX_WIDTH];
		logic [PIX_W-1:0]    left_px;
		logic [WIDTH_W-1:0]  width_reg;
		logic [HEIGHT_W-1:0] height_reg;
		int unsigned         col;
		int unsigned         row;
		bit                  draining;
		result_t             pending_medians [$];
		int                  faults;

		function new();
			foreach (older_row[i]) begin
				older_row[i] = '0;
				newer_row[i] = '0;
			end
			left_px    = '0;
			width_reg  = WIDTH_W'(1024);
			height_reg = HEIGHT_W'(1024);
			col        = 0;
			row        = 0;
			draining   = 1'b0;
			faults     = 0;
		endfunction

		function int unsigned clamp_size(int unsigned v, int unsigned lim);
			if (v < 1)
				return 1;
			if (v > lim)
				return lim;
			return v;
		endfunction

		function int unsigned frame_w();
			return clamp_size(32'(width_reg), MAX_WIDTH);
		endfunction

		function int unsigned frame_h();
			return clamp_size(32'(height_reg), MAX_HEIGHT);
		endfunction

		function int open_count();
			return pending_medians.size();
		endfunction

		// Counts a failure and tells whether it may still be printed.
		function bit fault();
			faults++;
			return faults <= REPORT_CAP;
		endfunction

		function void set_register(logic idx, logic [31:0] data);
			if (idx == REG_FRAME_WIDTH)
				width_reg = data[WIDTH_W-1:0];
			else
				height_reg = data[HEIGHT_W-1:0];
			col      = 0;
			row      = 0;
			draining = 1'b0;
		endfunction

		function logic signed [PIX_W-1:0] middle_of_five(logic signed [PIX_W-1:0] v [CROSS_SIZE]);
			logic signed [PIX_W-1:0] k [CROSS_SIZE];
			logic signed [PIX_W-1:0] t;
			int j;
			k = v;
			for (int i = 1; i < CROSS_SIZE; i++) begin
				t = k[i];
				j = i;
				while (j > 0 && k[j-1] > t) begin
					k[j] = k[j-1];
					j--;
				end
				k[j] = t;
			end
			return k[CROSS_SIZE / 2];
		endfunction

		// Missing neighbours take the centre value; the left neighbour is the centre of
		// the previous output in the same row.
		function logic signed [PIX_W-1:0] cross_median(int unsigned c, int unsigned w, bit has_up,
				logic signed [PIX_W-1:0] below, bit has_below);
			logic signed [PIX_W-1:0] v [CROSS_SIZE];
			logic signed [PIX_W-1:0] mid;
			mid  = newer_row[c];
			v[0] = mid;
			v[1] = has_up ? older_row[c] : mid;
			v[2] = has_below ? below : mid;
			v[3] = (c > 0) ? left_px : mid;
			v[4] = (c + 1 < w) ? newer_row[c + 1] : mid;
			left_px = mid;
			return middle_of_five(v);
		endfunction

		function void take_item(item_t it);
			int unsigned w, h, c;
			bit row_end;
			result_t r;
			w       = frame_w();
			h       = frame_h();
			c       = col;
			row_end = (c + 1 >= w);
			if (it.operation == OP_PIXEL) begin
				if (draining)
					return;
				if (row == 0) begin
					left_px = newer_row[c];
				end else begin
					r.median_value = cross_median(c, w, row >= 2, it.pixel_value, 1'b1);
					r.end_of_row   = row_end;
					r.end_of_frame = 1'b0;
					pending_medians.push_back(r);
				end
				older_row[c] = newer_row[c];
				newer_row[c] = it.pixel_value;
				if (row_end) begin
					col = 0;
					if (row + 1 >= h)
						draining = 1'b1;
					else
						row++;
				end else begin
					col = c + 1;
				end
			end else if (draining) begin
				r.median_value = cross_median(c, w, row >= 1, '0, 1'b0);
				r.end_of_row   = row_end;
				r.end_of_frame = row_end;
				pending_medians.push_back(r);
				if (row_end) begin
					col      = 0;
					row      = 0;
					draining = 1'b0;
				end else begin
					col = c + 1;
				end
			end
		endfunction

		function void match_median(result_t got);
			result_t want;
			if (pending_medians.size() == 0) begin
				if (fault())
					$display("%0t: unexpected result: median %0d eor %0b eof %0b", $time,
						got.median_value, got.end_of_row, got.end_of_frame);
				return;
			end
			want = pending_medians.pop_front();
			if (got.median_value !== want.median_value && fault())
				$display("%0t: median_value expected %0d actual %0d", $time,
					want.median_value, got.median_value);
			if (got.end_of_row !== want.end_of_row && fault())
				$display("%0t: end_of_row expected %0b actual %0b", $time,
					want.end_of_row, got.end_of_row);
			if (got.end_of_frame !== want.end_of_frame && fault())
				$display("%0t: end_of_frame expected %0b actual %0b", $time,
					want.end_of_frame, got.end_of_frame);
		endfunction
	endclass

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_ready;
	item_t       item         = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [2:0]  paddr        = '0;
	logic [31:0] pwdata       = '0;
	logic [31:0] prdata;
	logic        pready;

	cross_median_tracker tracker = new();

	int burst_left  = 0;
	bit gapless     = 1'b0;
	int items_sent  = 0;

	cross_median_filter_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic signed [PIX_W-1:0] next_pixel();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return $urandom;
			6, 7: return $signed($urandom_range(0, 8)) - 4;
			default: begin
				case ($urandom_range(0, 4))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					3: return 32'hffff_ffff;
					default: return 32'h0000_0001;
				endcase
			end
		endcase
	endfunction

	function automatic logic [31:0] rand_width();
		case ($urandom_range(0, 9))
			0: return 0;
			1, 2, 3, 4, 5, 6: return $urandom_range(1, 6);
			7, 8: return $urandom_range(7, 16);
			default: return $urandom_range(17, 48);
		endcase
	endfunction

	function automatic logic [31:0] rand_height();
		case ($urandom_range(0, 9))
			0: return 0;
			9: return $urandom_range(6, 10);
			default: return $urandom_range(1, 5);
		endcase
	endfunction

	task automatic send_item(item_t it);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!gapless)
				gap = $urandom_range(1, 7);
		end
		burst_left--;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_ready !== 1'b1);
		tracker.take_item(it);
	endtask

	task automatic send_op(logic op, logic signed [PIX_W-1:0] pix);
		item_t it;
		it.operation   = op;
		it.pixel_value = pix;
		send_item(it);
	endtask

	// Sends one frame in scan order followed by its flushes, cut short after stop_after
	// transactions. Stray transactions of the wrong kind are ignored by the block.
	task automatic run_frame(int unsigned w, int unsigned h, int unsigned stop_after, bit noisy);
		int unsigned pixels;
		pixels = w * h;
		for (int unsigned i = 0; i < stop_after; i++) begin
			if (noisy && $urandom_range(0, 15) == 0)
				send_op((i < pixels) ? OP_FLUSH : OP_PIXEL, next_pixel());
			send_op((i < pixels) ? OP_PIXEL : OP_FLUSH, next_pixel());
			items_sent++;
		end
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (tracker.open_count() != 0) @(posedge clk);
		repeat (IDLE_PAUSE) @(posedge clk);
	endtask

	task automatic apb_transfer(bit wr, logic idx, logic [31:0] data, output logic [31:0] rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
	endtask

	// Writes a register, sometimes with junk above its width, then reads it back.
	task automatic program_reg(logic idx, logic [31:0] value);
		logic [31:0] mask, data, rd;
		mask = (idx == REG_FRAME_WIDTH) ? (32'd1 << WIDTH_W) - 1 : (32'd1 << HEIGHT_W) - 1;
		data = value & mask;
		if ($urandom_range(0, 1))
			data = data | ($urandom & ~mask);
		apb_transfer(1'b1, idx, data, rd);
		tracker.set_register(idx, data);
		apb_transfer(1'b0, idx, '0, rd);
		if (rd !== (data & mask) && tracker.fault())
			$display("%0t: register %0d read expected %0h actual %0h", $time, idx,
				data & mask, rd);
	endtask

	task automatic program_frame(bit set_w, logic [31:0] wv, bit set_h, logic [31:0] hv);
		if (set_w)
			program_reg(REG_FRAME_WIDTH, wv);
		if (set_h)
			program_reg(REG_FRAME_HEIGHT, hv);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned w, h, total, stop_after, sel, nframes;
		bit broken;
		logic [31:0] big_w [4];
		logic [31:0] big_h [4];

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A few pixels of row 0 at the reset size, then a flush that is not draining.
		send_op(OP_PIXEL, 32'h1234_5678);
		send_op(OP_PIXEL, 32'h8000_0000);
		send_op(OP_PIXEL, 32'h7fff_ffff);
		send_op(OP_FLUSH, 32'hdead_beef);
		wait_idle();

		program_frame(1'b1, 3, 1'b1, 3);
		send_op(OP_PIXEL, 32'h8000_0000);
		send_op(OP_PIXEL, 32'h7fff_ffff);
		send_op(OP_PIXEL, 32'h0000_0000);
		send_op(OP_PIXEL, 32'hffff_ffff);
		send_op(OP_PIXEL, 32'h0000_0001);
		send_op(OP_PIXEL, 32'h8000_0000);
		send_op(OP_PIXEL, 32'h7fff_ffff);
		send_op(OP_PIXEL, 32'h7fff_ffff);
		send_op(OP_PIXEL, 32'h8000_0001);
		send_op(OP_PIXEL, 32'h5a5a_5a5a);
		send_op(OP_FLUSH, 32'hffff_ffff);
		send_op(OP_FLUSH, 32'h0000_0000);
		send_op(OP_FLUSH, 32'h7fff_ffff);
		send_op(OP_FLUSH, 32'h8000_0000);
		wait_idle();

		// Zero sizes act as a single pixel frame.
		program_frame(1'b1, 0, 1'b1, 0);
		send_op(OP_PIXEL, 32'h8000_0000);
		send_op(OP_FLUSH, 32'h0000_0000);
		send_op(OP_PIXEL, 32'h7fff_ffff);
		send_op(OP_FLUSH, 32'hffff_ffff);

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			wait_idle();
			gapless = ($urandom_range(0, 3) == 0);
			sel     = $urandom_range(0, 3);
			program_frame(sel != 1, rand_width(), sel != 0, rand_height());
			nframes = $urandom_range(1, 3);
			for (int f = 0; f < nframes; f++) begin
				w          = tracker.frame_w();
				h          = tracker.frame_h();
				total      = w * h + w;
				broken     = ($urandom_range(0, 6) == 0);
				stop_after = broken ? $urandom_range(0, total - 1) : total;
				run_frame(w, h, stop_after, 1'b1);
				if (broken)
					break;
			end
		end

		// Full and over-range sizes, each cut short after its first transactions.
		big_w = '{2047, 1024, 1, 1};
		big_h = '{2, 1, 4096, 8191};
		for (int i = 0; i < 4; i++) begin
			wait_idle();
			gapless = ($urandom_range(0, 1) == 0);
			program_frame(1'b1, big_w[i], 1'b1, big_h[i]);
			w     = tracker.frame_w();
			h     = tracker.frame_h();
			total = w * h + w;
			run_frame(w, h, (total < BIG_ITEMS) ? total : BIG_ITEMS, 1'b0);
		end

		wait_idle();
		if (tracker.faults == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin : result_sink
		sink_mode_e mode;
		int mode_left, run_left;
		logic rdy;
		mode      = SINK_READY;
		mode_left = 0;
		run_left  = 0;
		rdy       = 1'b1;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid === 1'b1 && result_ready)
				tracker.match_median(result);
			if (mode_left == 0) begin
				mode      = sink_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 400);
			end
			mode_left--;
			case (mode)
				SINK_READY: rdy = 1'b1;
				SINK_COIN: rdy = 1'($urandom_range(0, 1));
				SINK_RARE_STALL: rdy = ($urandom_range(0, 5) != 0);
				default: begin
					if (run_left == 0) begin
						rdy      = !rdy;
						run_left = rdy ? $urandom_range(1, 10) : $urandom_range(1, 12);
					end
					run_left--;
				end
			endcase
			result_ready <= rdy;
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

endmodule
